// ===== rtl/core/c8_pkg.sv =====
// shared types and constants for the chip8 instruction core
// depends on nothing
package c8_pkg;

    localparam int MemoryBytes  = 4096;
    localparam int StackDepth   = 16;
    localparam int ScreenWidth  = 64;
    localparam int ScreenHeight = 32;
    localparam logic [11:0] ProgramStartReset = 12'd512;
    localparam logic [11:0] FontBaseReset     = 12'd80;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_EXEC  = 2'd1,
        K_TICK  = 2'd2,
        K_ROW   = 2'd3
    } t_kind;

    localparam logic [0:0] CfgProgramStart = 1'b0;
    localparam logic [0:0] CfgFontBase     = 1'b1;

    localparam logic [7:0] FxGetDelay  = 8'h07;
    localparam logic [7:0] FxKeyWait   = 8'h0A;
    localparam logic [7:0] FxSetDelay  = 8'h15;
    localparam logic [7:0] FxSetSound  = 8'h18;
    localparam logic [7:0] FxFont      = 8'h29;
    localparam logic [7:0] FxBcd       = 8'h33;
    localparam logic [7:0] FxStore     = 8'h55;
    localparam logic [7:0] FxLoad      = 8'h65;
    localparam logic [11:0] OpCls      = 12'h0E0;
    localparam logic [11:0] OpRet      = 12'h0EE;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FETCH_HI,
        S_FETCH_LO,
        S_DECODE,
        S_CLS,
        S_DRAW_RD,
        S_DRAW_WAIT,
        S_DRAW_ROW,
        S_BCD,
        S_STORE,
        S_LOAD_RD,
        S_LOAD_WAIT,
        S_LOAD_WR,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic wait_key;
        logic changed;
        logic bad;
        logic sfault;
    } t_flags;

    // 8-bit value to three bcd digits, small shift-add network
    function automatic logic [11:0] to_bcd(input logic [7:0] v);
        logic [19:0] s;
        s = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
            if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
            s = s << 1;
        end
        return s[19:8];
    endfunction

endpackage

// ===== rtl/core/c8_alu.sv =====
// register ALU for the 8XYN group
// depends on c8_pkg
module c8_alu (
    input  logic [3:0] i_fn,
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    output logic [7:0] o_res,
    output logic [7:0] o_flag,
    output logic       o_wr_flag,
    output logic       o_bad
);
    import c8_pkg::*;
    logic [8:0] w_sum;
    logic [8:0] w_sub;
    logic [8:0] w_rsub;

    assign w_sum  = {1'b0, i_a} + {1'b0, i_b};
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign w_rsub = {1'b0, i_b} - {1'b0, i_a};

    always_comb begin
        o_res = i_a;
        o_flag = 8'd0;
        o_wr_flag = 1'b0;
        o_bad = 1'b0;
        case (i_fn)
            4'h0: o_res = i_b;
            4'h1: o_res = i_a | i_b;
            4'h2: o_res = i_a & i_b;
            4'h3: o_res = i_a ^ i_b;
            4'h4: begin
                o_res = w_sum[7:0]; o_flag = {7'd0, w_sum[8]}; o_wr_flag = 1'b1;
            end
            4'h5: begin
                o_res = w_sub[7:0]; o_flag = {7'd0, ~w_sub[8]}; o_wr_flag = 1'b1;
            end
            4'h6: begin
                o_res = {1'b0, i_a[7:1]}; o_flag = {7'd0, i_a[0]}; o_wr_flag = 1'b1;
            end
            4'h7: begin
                o_res = w_rsub[7:0]; o_flag = {7'd0, ~w_rsub[8]}; o_wr_flag = 1'b1;
            end
            4'hE: begin
                o_res = {i_a[6:0], 1'b0}; o_flag = {7'd0, i_a[7]}; o_wr_flag = 1'b1;
            end
            default: o_bad = 1'b1;
        endcase
    end
endmodule

// ===== rtl/core/chip8_instruction_core.sv =====
// Each word passes through one memory port. A memory write or timer tick ends in the idle
// state, a display row read passes a result state, a plain instruction makes two opcode
// byte reads, then decode, 00E0 clears one display row a cycle, DXYN reads a sprite byte,
// waits and does a read-modify-write of a display row per sprite row, FX33 writes three
// digits, FX55 writes X+1 bytes and FX65 reads, waits and writes per register.
// Memory and display rows live in single-port synchronous arrays with a registered read.
// After reset a pass clears all 32 display rows before the first word is taken.
// The result is held in an output register until taken; a new word is taken
// once the previous result has left.
module chip8_instruction_core #(
    parameter int STACK_DEPTH = c8_pkg::StackDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_keys_down,
    input  logic [7:0]  i_random_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_read_data,
    output logic [11:0] o_program_counter,
    output logic        o_sound_on,
    output logic        o_waiting_for_key,
    output logic        o_display_changed,
    output logic        o_bad_instruction,
    output logic        o_stack_fault
);
    import c8_pkg::*;
    localparam int SpW = $clog2(STACK_DEPTH + 1);
    localparam int SiW = $clog2(STACK_DEPTH);

    logic [7:0]  r_mem [MemoryBytes];
    logic [63:0] r_scr [ScreenHeight];
    logic [11:0] r_stk [STACK_DEPTH];

    t_state r_state, n_state;
    logic [11:0] r_fbase, r_pc, r_i;
    logic [7:0]  r_v [16];
    logic [SpW-1:0] r_sp;
    logic [7:0]  r_dt, r_st;
    logic [15:0] r_keys;
    logic [7:0]  r_rnd, r_hi, r_lo;
    logic [4:0]  r_cnt;
    logic [5:0]  r_px;
    logic [4:0]  r_row;
    logic        r_hit;
    logic [11:0] r_bcd;
    logic [63:0] r_data;
    t_flags      r_flags;
    logic        r_ovalid;

    // memory port
    logic        w_mwe;
    logic [11:0] w_maddr;
    logic [7:0]  w_mwd, r_mrd;
    always_ff @(posedge i_clk) begin
        if (w_mwe) r_mem[w_maddr] <= w_mwd;
        r_mrd <= r_mem[w_maddr];
    end

    // display port
    logic        w_swe;
    logic [4:0]  w_saddr;
    logic [63:0] w_swd, r_srd;
    always_ff @(posedge i_clk) begin
        if (w_swe) r_scr[w_saddr] <= w_swd;
        r_srd <= r_scr[w_saddr];
    end

    logic [3:0] w_x, w_y, w_n, w_op;
    logic [11:0] w_nnn;
    logic [7:0] w_vx, w_vy;
    assign w_op = r_hi[7:4];
    assign w_x = r_hi[3:0];
    assign w_y = r_lo[7:4];
    assign w_n = r_lo[3:0];
    assign w_nnn = {w_x, r_lo};
    assign w_vx = r_v[w_x];
    assign w_vy = r_v[w_y];

    logic [7:0] w_ares, w_aflag;
    logic w_awf, w_abad;
    c8_alu u_alu (
        .i_fn(w_n), .i_a(w_vx), .i_b(w_vy),
        .o_res(w_ares), .o_flag(w_aflag), .o_wr_flag(w_awf), .o_bad(w_abad)
    );

    logic [63:0] w_line;
    assign w_line = {r_mrd, 56'd0} >> r_px;

    logic [3:0] w_key;
    always_comb begin
        w_key = 4'd0;
        for (int k = 15; k >= 0; k--) if (r_keys[k]) w_key = 4'(k);
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid && o_ready)
                n_state = (t_kind'(i_kind) == K_EXEC) ? S_FETCH_HI :
                          (t_kind'(i_kind) == K_ROW) ? S_RESULT : S_IDLE;
            S_FETCH_HI: n_state = S_FETCH_LO;
            S_FETCH_LO: n_state = S_DECODE;
            S_DECODE: begin
                n_state = S_IDLE;
                if (w_op == 4'h0 && w_nnn == OpCls) n_state = S_CLS;
                else if (w_op == 4'hD)
                    n_state = (w_n == 4'd0) ? S_IDLE : S_DRAW_RD;
                else if (w_op == 4'hF && r_lo == FxBcd) n_state = S_BCD;
                else if (w_op == 4'hF && r_lo == FxStore) n_state = S_STORE;
                else if (w_op == 4'hF && r_lo == FxLoad) n_state = S_LOAD_RD;
            end
            S_CLS: if (r_cnt == 5'd31) n_state = S_IDLE;
            S_DRAW_RD: n_state = S_DRAW_WAIT;
            S_DRAW_WAIT: n_state = S_DRAW_ROW;
            S_DRAW_ROW:
                n_state = (r_cnt[3:0] == w_n - 4'd1 || r_row == 5'd31) ? S_IDLE : S_DRAW_RD;
            S_BCD: if (r_cnt == 5'd2) n_state = S_IDLE;
            S_STORE: if (r_cnt[3:0] == w_x) n_state = S_IDLE;
            S_LOAD_RD: n_state = S_LOAD_WAIT;
            S_LOAD_WAIT: n_state = S_LOAD_WR;
            S_LOAD_WR: n_state = (r_cnt[3:0] == w_x) ? S_IDLE : S_LOAD_RD;
            S_RESULT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // port addressing
    always_comb begin
        w_mwe = 1'b0;
        w_maddr = r_pc;
        w_mwd = r_v[r_cnt[3:0]];
        w_swe = 1'b0;
        w_saddr = r_row;
        w_swd = r_srd ^ w_line;
        case (r_state)
            S_IDLE: begin
                // an instruction word starts its fetch at the program counter
                w_maddr = (t_kind'(i_kind) == K_EXEC) ? r_pc : i_address;
                w_mwd = i_write_data;
                w_mwe = i_valid && o_ready && t_kind'(i_kind) == K_WRITE;
                w_saddr = i_address[4:0];
            end
            S_FETCH_HI: w_maddr = r_pc + 12'd1;
            S_CLS: begin
                w_swe = 1'b1; w_saddr = r_cnt; w_swd = 64'd0;
            end
            // keep the address during the wait so the read data stays put
            S_DRAW_RD, S_DRAW_WAIT: w_maddr = r_i + {7'd0, r_cnt};
            S_DRAW_ROW: w_swe = 1'b1;
            S_BCD: begin
                w_mwe = 1'b1;
                w_maddr = r_i + {7'd0, r_cnt};
                w_mwd = (r_cnt == 5'd0) ? {4'd0, r_bcd[11:8]} :
                        (r_cnt == 5'd1) ? {4'd0, r_bcd[7:4]} : {4'd0, r_bcd[3:0]};
            end
            S_STORE: begin
                w_mwe = 1'b1; w_maddr = r_i + {7'd0, r_cnt};
            end
            S_LOAD_RD, S_LOAD_WAIT: w_maddr = r_i + {7'd0, r_cnt};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // display clearing pass runs right after reset
            r_state <= S_CLS;
            r_cnt <= 5'd0;
            r_fbase <= FontBaseReset;
            r_pc <= ProgramStartReset;
            r_i <= 12'd0;
            r_sp <= '0;
            r_dt <= 8'd0;
            r_st <= 8'd0;
            r_ovalid <= 1'b0;
            r_flags <= '0;
            r_data <= 64'd0;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == CfgProgramStart) begin
                    r_pc <= i_cfg_data;
                end else begin
                    r_fbase <= i_cfg_data;
                end
            end
            // the clearing pass after reset leaves no word behind
            if (n_state == S_IDLE && r_state != S_IDLE &&
                !(r_state == S_CLS && !r_flags.changed)) r_ovalid <= 1'b1;
            case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_keys <= i_keys_down; r_rnd <= i_random_byte;
                    r_flags <= '0; r_data <= 64'd0; r_cnt <= 5'd0;
                    if (t_kind'(i_kind) == K_TICK) begin
                        if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                        if (r_st != 8'd0) r_st <= r_st - 8'd1;
                    end
                    if (t_kind'(i_kind) != K_EXEC && t_kind'(i_kind) != K_ROW)
                        r_ovalid <= 1'b1;
                end
                S_RESULT: r_data <= r_srd;
                S_FETCH_HI: r_hi <= r_mrd;
                S_FETCH_LO: begin
                    r_lo <= r_mrd;
                    r_pc <= r_pc + 12'd2;
                end
                S_DECODE: begin
                    r_cnt <= 5'd0;
                    r_hit <= 1'b0;
                    r_px <= w_vx[5:0];
                    r_row <= w_vy[4:0];
                    r_bcd <= to_bcd(w_vx);
                    case (w_op)
                        4'h0: begin
                            if (w_nnn == OpCls) r_flags.changed <= 1'b1;
                            else if (w_nnn == OpRet) begin
                                if (r_sp == '0) r_flags.sfault <= 1'b1;
                                else begin
                                    r_sp <= r_sp - 1'b1;
                                    r_pc <= r_stk[SiW'(r_sp - 1'b1)];
                                end
                            end else r_flags.bad <= 1'b1;
                        end
                        4'h1: r_pc <= w_nnn;
                        4'h2: begin
                            if (r_sp >= SpW'(STACK_DEPTH)) r_flags.sfault <= 1'b1;
                            else begin
                                r_stk[SiW'(r_sp)] <= r_pc;
                                r_sp <= r_sp + 1'b1;
                                r_pc <= w_nnn;
                            end
                        end
                        4'h3: if (w_vx == r_lo) r_pc <= r_pc + 12'd2;
                        4'h4: if (w_vx != r_lo) r_pc <= r_pc + 12'd2;
                        4'h5: if (w_vx == w_vy) r_pc <= r_pc + 12'd2;
                        4'h6: r_v[w_x] <= r_lo;
                        4'h7: r_v[w_x] <= w_vx + r_lo;
                        4'h8: begin
                            if (w_abad) r_flags.bad <= 1'b1;
                            else begin
                                // flag wins when VF is also the destination
                                if (!w_awf || w_x != 4'hF) r_v[w_x] <= w_ares;
                                if (w_awf) r_v[15] <= w_aflag;
                            end
                        end
                        4'h9: if (w_vx != w_vy) r_pc <= r_pc + 12'd2;
                        4'hA: r_i <= w_nnn;
                        4'hB: r_pc <= {4'd0, r_v[0]} + w_nnn;
                        4'hC: r_v[w_x] <= r_rnd & r_lo;
                        4'hD: begin
                            r_flags.changed <= 1'b1;
                            if (w_n == 4'd0) r_v[15] <= 8'd0;
                        end
                        4'hF: begin
                            case (r_lo)
                                FxGetDelay: r_v[w_x] <= r_dt;
                                FxKeyWait: begin
                                    if (r_keys == 16'd0) begin
                                        r_pc <= r_pc - 12'd2;
                                        r_flags.wait_key <= 1'b1;
                                    end else r_v[w_x] <= {4'd0, w_key};
                                end
                                FxSetDelay: r_dt <= w_vx;
                                FxSetSound: r_st <= w_vx;
                                FxFont: r_i <= r_fbase + 12'(w_vx[3:0]) * 12'd5;
                                FxBcd, FxStore, FxLoad: ;
                                default: r_flags.bad <= 1'b1;
                            endcase
                        end
                        default: r_flags.bad <= 1'b1;
                    endcase
                end
                S_CLS: r_cnt <= r_cnt + 5'd1;
                S_DRAW_ROW: begin
                    if ((r_srd & w_line) != 64'd0 || r_hit) begin
                        r_hit <= 1'b1;
                    end
                    r_cnt <= r_cnt + 5'd1;
                    r_row <= r_row + 5'd1;
                    if (n_state == S_IDLE)
                        r_v[15] <= {7'd0, r_hit | ((r_srd & w_line) != 64'd0)};
                end
                S_BCD: r_cnt <= r_cnt + 5'd1;
                S_STORE: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (n_state == S_IDLE) r_i <= r_i + {8'd0, w_x} + 12'd1;
                end
                S_LOAD_WR: begin
                    r_v[r_cnt[3:0]] <= r_mrd;
                    r_cnt <= r_cnt + 5'd1;
                    if (n_state == S_IDLE) r_i <= r_i + {8'd0, w_x} + 12'd1;
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_read_data = r_data;
    assign o_program_counter = r_pc;
    assign o_sound_on = r_st != 8'd0;
    assign o_waiting_for_key = r_flags.wait_key;
    assign o_display_changed = r_flags.changed;
    assign o_bad_instruction = r_flags.bad;
    assign o_stack_fault = r_flags.sfault;

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SpW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_ovalid && r_state == S_IDLE) else $error("ready while busy");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid) else $error("result dropped");
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> $onehot0({r_flags.bad, r_flags.sfault, r_flags.wait_key}))
        else $error("conflicting flags");
endmodule
